### rtl/acf_pkg.sv
`default_nettype none

package acf_pkg;

  localparam int ID_W   = 11;
  localparam int WORD_W = 12;
  localparam int CNT_W  = 6;
  localparam int IDX_W  = 5;
  localparam int DLC_W  = 4;
  localparam int LEN_W  = 4;

  localparam logic [DLC_W-1:0] MAX_DLC = 4'd8;

  typedef enum logic [2:0] {
    ST_WRITTEN   = 3'd0,
    ST_REJECTED  = 3'd1,
    ST_DELIVERED = 3'd2,
    ST_NO_MATCH  = 3'd3,
    ST_UNARMED   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_t;

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_FRAME = 1'b1
  } mode_t;

  typedef struct packed {
    logic [0:0]       mode;
    logic [IDX_W-1:0] entry_index;
    logic [ID_W-1:0]  identifier;
    logic [ID_W-1:0]  id_mask;
    logic [0:0]       remote;
    logic [DLC_W-1:0] length_code;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] hit_index;
    logic [LEN_W-1:0] data_length;
  } rsp_t;

  // stored word: remote bit above identifier; mask remote bit is implied set
  typedef struct packed {
    logic [WORD_W-1:0] ident;
    logic [ID_W-1:0]   mask;
  } entry_wr_t;

  typedef struct packed {
    logic              armed;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] ident;
  } entry_t;

  function automatic logic [LEN_W-1:0] decode_length(input logic [DLC_W-1:0] code);
    decode_length = (code <= MAX_DLC) ? LEN_W'(code) : '0;
  endfunction

endpackage

`default_nettype wire

### rtl/acf_entry_ram.sv
`default_nettype none

module acf_entry_ram import acf_pkg::*; #(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire entry_wr_t         wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output entry_t                 rdata
);

  entry_wr_t        mem [DEPTH];
  logic [DEPTH-1:0] valid;
  entry_wr_t        rd_word;
  logic             rd_valid;

  // a written entry is armed; an unwritten one reads as ident 0, mask all ones
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= valid[raddr];
      if (we) begin
        valid[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_word <= mem[raddr];
  end

  always_comb begin
    rdata.armed = rd_valid;
    rdata.mask  = rd_valid ? {1'b1, rd_word.mask} : '1;
    rdata.ident = rd_valid ? rd_word.ident : '0;
  end

endmodule

`default_nettype wire

### rtl/acf_scan_ctrl.sv
`default_nettype none

module acf_scan_ctrl import acf_pkg::*; #(
  parameter int ADDR_W = 5
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [CNT_W-1:0]  count,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire req_t              req,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output rsp_t                   rsp,
  output logic                   ram_we,
  output logic [ADDR_W-1:0]      ram_waddr,
  output entry_wr_t              ram_wdata,
  output logic [ADDR_W-1:0]      ram_raddr,
  input  wire entry_t            ram_rdata
);

  state_t            state, state_next;
  logic [CNT_W-1:0]  k;
  logic [WORD_W-1:0] frame_word;
  rsp_t              res;

  logic              accept;
  logic              write_ok;
  logic              hit;
  logic              last;
  logic              load_rsp;
  logic [CNT_W-1:0]  rd_idx;
  logic [15:0]       waddr_wide;
  logic [15:0]       raddr_wide;

  assign accept   = req_valid && req_ready;
  assign write_ok = {1'b0, req.entry_index} < count;
  assign hit      = ((frame_word ^ ram_rdata.ident) & ram_rdata.mask) == '0;
  assign last     = k == count - CNT_W'(1);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req.mode == MODE_WRITE || count == '0) begin
            state_next = S_EMIT;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit || last) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    ram_we    = 1'b0;
    load_rsp  = 1'b0;
    rd_idx    = '0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        ram_we    = req_valid && req.mode == MODE_WRITE && write_ok;
      end
      S_SCAN: begin
        // fetch the next entry while this one is compared
        if (!last) begin
          rd_idx = k + CNT_W'(1);
        end
      end
      S_EMIT: begin
        load_rsp = !rsp_valid || rsp_ready;
      end
      default: ;
    endcase
  end

  assign waddr_wide      = 16'(req.entry_index);
  assign raddr_wide      = 16'(rd_idx);
  assign ram_waddr       = waddr_wide[ADDR_W-1:0];
  assign ram_raddr       = raddr_wide[ADDR_W-1:0];
  assign ram_wdata.ident = {req.remote, req.identifier};
  assign ram_wdata.mask  = req.id_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      k          <= '0;
      frame_word <= {req.remote, req.identifier};
      res.hit_index <= '0;
      if (req.mode == MODE_WRITE) begin
        res.status      <= write_ok ? ST_WRITTEN : ST_REJECTED;
        res.data_length <= '0;
      end else begin
        res.status      <= ST_NO_MATCH;
        res.data_length <= decode_length(req.length_code);
      end
    end else if (state == S_SCAN) begin
      if (hit) begin
        res.status    <= ram_rdata.armed ? ST_DELIVERED : ST_UNARMED;
        res.hit_index <= k[IDX_W-1:0];
      end else begin
        k <= k + CNT_W'(1);
      end
    end
    if (load_rsp) begin
      rsp <= res;
    end
  end

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> k < count)
    else $error("scan index beyond active entries");

  a_write_fields_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_WRITTEN || rsp.status == ST_REJECTED)
      |-> rsp.hit_index == '0 && rsp.data_length == '0)
    else $error("write result carries hit or length");

  a_no_match_index: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_NO_MATCH |-> rsp.hit_index == '0)
    else $error("no-match result with non-zero index");

  a_length_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.data_length <= LEN_W'(MAX_DLC))
    else $error("decoded length above eight bytes");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("request accepted but controller stayed idle");

endmodule

`default_nettype wire

### rtl/can_rx_acceptance_filter_top.sv
// CAN receive acceptance filter for standard 11-bit identifiers.
// Request channel (req_valid/req_ready, req): mode 0 writes one filter entry
// (identifier, remote flag, 11-bit mask; the remote bit is always compared) and
// arms it if its index is below the active entry count, else rejects it; mode 1
// presents a received frame for matching. Every request gives exactly one
// response on rsp_valid/rsp_ready, rsp. A frame is matched against the entry
// table from index 0 up; the first entry whose masked identifier matches ends
// the scan. Entries live in a synchronous RAM, one entry read per cycle while
// scanning; at most count entries (active_entries clamped to the table size)
// are examined, then the emit state loads the response register and the
// controller returns to idle to take the next request. A write, or a frame
// with no active entries, goes from idle straight to the emit state.
// One request is in flight at a time; req_ready is high only while idle.
// The response sits in an output register: a stalled receiver holds it while
// the next request is accepted and processed, which then waits to load.
// cfg_we/cfg_wdata set active_entries (reset 32, saturated at the table size);
// write only while no request is outstanding.
// Reset (synchronous) clears all armed flags at once, so every entry reads as
// identifier 0, mask all ones, unarmed; no clearing pass is needed.
`default_nettype none

module can_rx_acceptance_filter_top import acf_pkg::*; #(
  parameter int FILTER_ENTRIES = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire req_t             req,
  output logic                  rsp_valid,
  input  wire logic             rsp_ready,
  output rsp_t                  rsp
);

  localparam int ADDR_W = (FILTER_ENTRIES > 1) ? $clog2(FILTER_ENTRIES) : 1;
  localparam logic [8:0] TABLE_SIZE = 9'(FILTER_ENTRIES);

  logic [CNT_W-1:0]  active_entries;
  logic [CNT_W-1:0]  count;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  entry_wr_t         ram_wdata;
  entry_t            ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_entries <= CNT_W'(32);
    end else if (cfg_we) begin
      active_entries <= cfg_wdata;
    end
  end

  // count above the table size is clamped
  assign count = ({3'b0, active_entries} > TABLE_SIZE) ? TABLE_SIZE[CNT_W-1:0]
                                                       : active_entries;

  acf_entry_ram #(
    .DEPTH  (FILTER_ENTRIES),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  acf_scan_ctrl #(
    .ADDR_W (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .count     (count),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

endmodule

`default_nettype wire
